### rtl/can_frame_change_filter_assert.svh
// assertion macros used by the can frame change filter datapath
// no dependencies; included inside module bodies after the logic
`ifndef CAN_FRAME_CHANGE_FILTER_ASSERT_SVH
`define CAN_FRAME_CHANGE_FILTER_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define CFCF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfcf assertion failed");

// next-cycle implication, checked while out of reset
`define CFCF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfcf assertion failed");

`endif

### rtl/cfcf_pkg.sv
// types and constants for the can frame change filter
// no dependencies; compiled first
package cfcf_pkg;

    localparam int ID_W          = 29;
    localparam int LEN_W         = 4;
    localparam int PAYLOAD_BYTES = 8;
    localparam int DATA_W        = 8 * PAYLOAD_BYTES;
    localparam int MASK_W        = PAYLOAD_BYTES;
    localparam int TRACK_W       = 7;
    localparam logic [TRACK_W-1:0] TRACK_MAX = 7'd127;
    localparam logic [LEN_W-1:0]   CMP_LEN_MAX = 4'd8;

    // one frame as received, also the layout of a table slot
    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [LEN_W-1:0]  frame_length;
        logic [DATA_W-1:0] frame_bytes;
    } t_frame;

    // one emitted result
    typedef struct packed {
        logic [ID_W-1:0]    out_id;
        logic [LEN_W-1:0]   out_length;
        logic [DATA_W-1:0]  out_bytes;
        logic               first_seen;
        logic [MASK_W-1:0]  byte_changed_mask;
        logic               length_changed;
        logic [LEN_W-1:0]   old_length;
        logic               table_full;
        logic [TRACK_W-1:0] ids_tracked;
    } t_result;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_COMMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic eval;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic miss;
        logic pass;
        logic out_free;
    } t_stat;

endpackage

### rtl/cfcf_if.sv
// valid/ready channel interfaces for frames in and results out
// depends on cfcf_pkg
interface cfcf_frame_if;
    logic                          valid;
    logic                          ready;
    logic [cfcf_pkg::ID_W-1:0]     frame_id;
    logic [cfcf_pkg::LEN_W-1:0]    frame_length;
    logic [cfcf_pkg::DATA_W-1:0]   frame_bytes;

    modport source (output valid, frame_id, frame_length, frame_bytes, input ready);
    modport sink   (input valid, frame_id, frame_length, frame_bytes, output ready);
endinterface

interface cfcf_result_if;
    logic                          valid;
    logic                          ready;
    logic [cfcf_pkg::ID_W-1:0]     out_id;
    logic [cfcf_pkg::LEN_W-1:0]    out_length;
    logic [cfcf_pkg::DATA_W-1:0]   out_bytes;
    logic                          first_seen;
    logic [cfcf_pkg::MASK_W-1:0]   byte_changed_mask;
    logic                          length_changed;
    logic [cfcf_pkg::LEN_W-1:0]    old_length;
    logic                          table_full;
    logic [cfcf_pkg::TRACK_W-1:0]  ids_tracked;

    modport source (output valid, out_id, out_length, out_bytes, first_seen,
                    byte_changed_mask, length_changed, old_length, table_full,
                    ids_tracked, input ready);
    modport sink   (input valid, out_id, out_length, out_bytes, first_seen,
                    byte_changed_mask, length_changed, old_length, table_full,
                    ids_tracked, output ready);
endinterface

### rtl/cfcf_ctrl.sv
// sequencer of the filter: accept, scan the slot table, evaluate, commit
// depends on cfcf_pkg
module cfcf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output cfcf_pkg::t_cmd  o_cmd,
    input  cfcf_pkg::t_stat i_stat
);
    import cfcf_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   commit_ok;

    // a dropped frame commits at once, a passing one waits for the output register
    assign commit_ok = !i_stat.pass || i_stat.out_free;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.hit || i_stat.miss) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (commit_ok) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            S_COMMIT: begin
                o_cmd.commit = commit_ok;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/cfcf_datapath.sv
// slot table memory, linear id search, change compare and result register
// depends on cfcf_pkg and can_frame_change_filter_assert.svh
module cfcf_datapath #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfcf_pkg::t_frame  i_frame,
    input  cfcf_pkg::t_cmd    i_cmd,
    output cfcf_pkg::t_stat   o_stat,
    output cfcf_pkg::t_result o_res,
    output logic              o_res_valid,
    input  logic              i_res_ready
);
    import cfcf_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    // slot memory, filled in order from slot 0, never freed
    t_frame mem [TABLE_ENTRIES];

    // frame under work and search state
    t_frame          r_key;
    logic [CW-1:0]   r_used,   n_used;
    logic [CW-1:0]   r_idx,    n_idx;
    logic            r_rd_vld, n_rd_vld;
    logic            r_hit,    n_hit;
    t_frame          r_rd;
    logic [CW-1:0]   r_rd_idx;

    // evaluation results
    logic              r_first;
    logic [MASK_W-1:0] r_mask;
    logic              r_len_chg;
    logic [LEN_W-1:0]  r_old_len;
    logic              r_full;
    logic              r_pass;

    // output register
    t_result         r_out;
    logic            r_out_vld, n_out_vld;

    logic              hit_now;
    logic              issue;
    logic              store_new;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [LEN_W-1:0]  cmp_len;
    logic [MASK_W-1:0] e_mask;
    logic              e_same;
    logic [CW-1:0]     used_after;
    logic [TRACK_W-1:0] track_val;

    // search: one slot read per cycle, each compared in the cycle after its read
    assign hit_now = i_cmd.scan && !r_hit && r_rd_vld && (r_rd.frame_id == r_key.frame_id);
    assign issue   = i_cmd.scan && !r_hit && !hit_now && (r_idx < r_used);

    // byte compare against the matched slot
    always_comb begin
        cmp_len = (r_key.frame_length > CMP_LEN_MAX) ? CMP_LEN_MAX : r_key.frame_length;
        e_mask  = '0;
        e_same  = 1'b1;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            if (LEN_W'(i) < cmp_len) begin
                if (r_key.frame_bytes[8*i +: 8] != r_rd.frame_bytes[8*i +: 8]) begin
                    e_same    = 1'b0;
                    e_mask[i] = 1'b1;
                end
                if (LEN_W'(i) >= r_rd.frame_length) e_mask[i] = 1'b1;
            end
        end
    end

    // write-back on commit of a passing frame, unless it is a new id and the table is full
    assign store_new  = r_first && !r_full;
    assign wr_en      = i_cmd.commit && r_pass && (store_new || !r_first);
    assign wr_addr    = store_new ? r_used[AW-1:0] : r_rd_idx[AW-1:0];
    assign used_after = r_used + CW'(store_new);
    assign track_val  = (32'(used_after) > 32'(TRACK_MAX)) ? TRACK_MAX
                                                           : TRACK_W'(used_after);

    // next values of control registers
    always_comb begin
        n_used    = r_used;
        n_idx     = r_idx;
        n_rd_vld  = r_rd_vld;
        n_hit     = r_hit;
        n_out_vld = r_out_vld;
        if (i_cmd.load) begin
            n_idx    = '0;
            n_rd_vld = 1'b0;
            n_hit    = 1'b0;
        end
        if (i_cmd.scan) begin
            n_rd_vld = issue;
            if (issue)   n_idx = r_idx + CW'(1);
            if (hit_now) n_hit = 1'b1;
        end
        if (r_out_vld && i_res_ready) n_out_vld = 1'b0;
        if (i_cmd.commit && r_pass) begin
            n_out_vld = 1'b1;
            n_used    = used_after;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_used    <= n_used;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_hit     <= n_hit;
            r_out_vld <= n_out_vld;
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= r_key;
        if (issue) begin
            r_rd     <= mem[r_idx[AW-1:0]];
            r_rd_idx <= r_idx;
        end
    end

    // payload registers: captured frame, evaluation, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_key <= i_frame;
        if (i_cmd.eval) begin
            if (r_hit) begin
                r_first   <= 1'b0;
                r_full    <= 1'b0;
                r_mask    <= e_mask;
                r_old_len <= r_rd.frame_length;
                r_len_chg <= (r_rd.frame_length != r_key.frame_length);
                r_pass    <= (r_rd.frame_length != r_key.frame_length) || !e_same;
            end else begin
                r_first   <= 1'b1;
                r_full    <= (r_used == FULL_COUNT);
                r_mask    <= '0;
                r_old_len <= '0;
                r_len_chg <= 1'b0;
                r_pass    <= 1'b1;
            end
        end
        if (i_cmd.commit && r_pass) begin
            r_out.out_id            <= r_key.frame_id;
            r_out.out_length        <= r_key.frame_length;
            r_out.out_bytes         <= r_key.frame_bytes;
            r_out.first_seen        <= r_first;
            r_out.byte_changed_mask <= r_mask;
            r_out.length_changed    <= r_len_chg;
            r_out.old_length        <= r_old_len;
            r_out.table_full        <= r_full;
            r_out.ids_tracked       <= track_val;
        end
    end

    // status and outputs
    assign o_stat.hit      = r_hit;
    assign o_stat.miss     = !r_hit && !r_rd_vld && !(r_idx < r_used);
    assign o_stat.pass     = r_pass;
    assign o_stat.out_free = !r_out_vld || i_res_ready;
    assign o_res           = r_out;
    assign o_res_valid     = r_out_vld;

    `include "can_frame_change_filter_assert.svh"

    // fill count never passes the table size
    `CFCF_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, 32'(r_used) <= 32'(TABLE_ENTRIES))
    // a match always points at a filled slot
    `CFCF_ASSERT_IMP(a_hit_in_table, i_clk, i_rst_n, r_hit, r_rd_idx < r_used)
    // the fill count moves only on a commit
    `CFCF_ASSERT_NXT(a_used_on_commit, i_clk, i_rst_n, !i_cmd.commit, $stable(r_used))
    // a new result never overwrites one that has not been taken
    `CFCF_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, i_cmd.commit && r_pass,
                     !r_out_vld || i_res_ready)

endmodule

### rtl/can_frame_change_filter.sv
// sequence: an accepted frame passes the scan, evaluate and commit states before the result
// register load; the scan is a linear id search over the single-read-port slot memory,
// one slot per cycle, so it grows with the number of tracked ids
// flow: one frame at a time; the next frame is taken in the cycle after commit,
// and commit of a passing frame waits while an earlier result waits to be taken
// reset: synchronous, active low; the table reads empty at once, no clearing pass
module can_frame_change_filter #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfcf_frame_if.sink    i_frame,
    cfcf_result_if.source o_result
);
    import cfcf_pkg::*;

    t_cmd    cmd;
    t_stat   stat;
    t_frame  frame;
    t_result res;
    logic    res_valid;

    // input payload gathered into one word
    assign frame.frame_id     = i_frame.frame_id;
    assign frame.frame_length = i_frame.frame_length;
    assign frame.frame_bytes  = i_frame.frame_bytes;

    // controller
    cfcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_frame.valid),
        .o_in_ready (i_frame.ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    // datapath
    cfcf_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (frame),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (o_result.ready)
    );

    // result channel
    assign o_result.valid             = res_valid;
    assign o_result.out_id            = res.out_id;
    assign o_result.out_length        = res.out_length;
    assign o_result.out_bytes         = res.out_bytes;
    assign o_result.first_seen        = res.first_seen;
    assign o_result.byte_changed_mask = res.byte_changed_mask;
    assign o_result.length_changed    = res.length_changed;
    assign o_result.old_length        = res.old_length;
    assign o_result.table_full        = res.table_full;
    assign o_result.ids_tracked       = res.ids_tracked;

endmodule
